### hw/rtl/receive_ring_fifo_overwrite_defines.svh
// ----------------------------------------------------------------------------
// receive_ring_fifo_overwrite_defines
// Assertion macros for the receive ring buffer. They expand to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RECEIVE_RING_FIFO_OVERWRITE_DEFINES_SVH
`define RECEIVE_RING_FIFO_OVERWRITE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define RRFO_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define RRFO_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RRFO_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RRFO_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### hw/rtl/rrfo_pkg.sv
// ----------------------------------------------------------------------------
// rrfo_pkg
// Shared constants, types and helpers of the receive ring buffer.
// ----------------------------------------------------------------------------
package rrfo_pkg;

	// ring geometry
	localparam int RING_DEPTH = 32;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	// fixed field widths
	localparam int BYTE_W = 8;
	localparam int FILL_W = 6;
	localparam int OP_W   = 2;

	localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// where a peek register takes its next value from
	typedef enum logic [1:0] {
		SRC_KEEP  = 2'd0,
		SRC_DATA  = 2'd1,
		SRC_RAM   = 2'd2,
		SRC_EMPTY = 2'd3
	} peek_src_t;

	// operation record handed from the index stage to the peek stage
	typedef struct packed {
		peek_src_t head_src;
		peek_src_t tail_src;
		logic      pop_hit;
		logic      was_empty;
		logic      dropped;
		cnt_t      count;
		byte_t     data;
	} s1_t;

	// advance a ring position with wrap
	function automatic idx_t ring_next(idx_t pos);
		return (pos == idx_t'(RING_DEPTH - 1)) ? '0 : idx_t'(pos + 1'b1);
	endfunction

endpackage

### hw/rtl/receive_ring_fifo_overwrite.sv
// Pipeline: an input transfer loads the stage 1 register; the result register
//   loads from stage 1 when it advances, which an output stall can hold off.
// Throughput: one operation per cycle unless the output stalls; the byte store
//   read port is registered: the new head byte reaches the peek stage next cycle.
// Reset: indices cleared, ring empty, pipeline and result register empty.
//   The byte store is not cleared; only held entries are ever used.
// ----------------------------------------------------------------------------
// receive_ring_fifo_overwrite
// Byte receive ring buffer that drops the oldest byte on a push into a full
// ring. Stage 0 updates indices, count and store; stage 1 resolves the head
// and tail peeks; a result register feeds the output channel.
// ----------------------------------------------------------------------------
`include "receive_ring_fifo_overwrite_defines.svh"

module receive_ring_fifo_overwrite (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] push_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_byte,
	output logic       read_was_empty,
	output logic       dropped_oldest,
	output logic [5:0] fill_count,
	output logic [7:0] head_byte,
	output logic [7:0] tail_byte
);

	localparam rrfo_pkg::cnt_t FULL_CNT = rrfo_pkg::cnt_t'(rrfo_pkg::RING_DEPTH);
	localparam rrfo_pkg::cnt_t ONE_CNT  = rrfo_pkg::cnt_t'(1);

	// ring state
	rrfo_pkg::idx_t  head_q, tail_q, head_d, tail_d;
	rrfo_pkg::cnt_t  count_q, count_d;
	rrfo_pkg::s1_t   s1_d, s1_s1;
	logic            s1_valid_s1;
	logic            s1_adv, in_acc;

	// store port controls
	logic            wr_en_c;
	rrfo_pkg::idx_t  wr_addr_c, rd_addr_c;
	rrfo_pkg::byte_t ram_rdata;

	// peek cache and next values
	rrfo_pkg::byte_t head_peek_q, tail_peek_q, head_new, tail_new, rd_new;

	// result register
	logic            out_valid_q;
	rrfo_pkg::byte_t read_byte_q, head_byte_q, tail_byte_q;
	logic            was_empty_q, dropped_q;
	rrfo_pkg::cnt_t  cnt_q;

	// handshake
	assign s1_adv   = s1_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_s1 && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	// stage 0: index, count and store update
	always_comb begin
		head_d         = head_q;
		tail_d         = tail_q;
		count_d        = count_q;
		wr_en_c        = 1'b0;
		wr_addr_c      = rrfo_pkg::ring_next(tail_q);
		rd_addr_c      = rrfo_pkg::ring_next(head_q);
		s1_d.head_src  = rrfo_pkg::SRC_KEEP;
		s1_d.tail_src  = rrfo_pkg::SRC_KEEP;
		s1_d.pop_hit   = 1'b0;
		s1_d.was_empty = 1'b0;
		s1_d.dropped   = 1'b0;
		s1_d.data      = push_byte;
		unique case (rrfo_pkg::op_t'(opcode))
			rrfo_pkg::OP_PUSH: begin
				wr_en_c       = 1'b1;
				s1_d.tail_src = rrfo_pkg::SRC_DATA;
				if (count_q == '0) begin
					// first byte lands at position zero
					head_d        = '0;
					tail_d        = '0;
					count_d       = ONE_CNT;
					wr_addr_c     = '0;
					s1_d.head_src = rrfo_pkg::SRC_DATA;
				end else if (count_q == FULL_CNT) begin
					// full: drop the oldest, new head byte comes from the store
					head_d        = rrfo_pkg::ring_next(head_q);
					tail_d        = rrfo_pkg::ring_next(tail_q);
					s1_d.dropped  = 1'b1;
					s1_d.head_src = rrfo_pkg::SRC_RAM;
				end else begin
					tail_d  = rrfo_pkg::ring_next(tail_q);
					count_d = count_q + ONE_CNT;
				end
			end
			rrfo_pkg::OP_POP: begin
				if (count_q == '0) begin
					s1_d.was_empty = 1'b1;
				end else begin
					s1_d.pop_hit = 1'b1;
					if (count_q == ONE_CNT) begin
						// last byte leaves, indices stay
						count_d       = '0;
						s1_d.head_src = rrfo_pkg::SRC_EMPTY;
						s1_d.tail_src = rrfo_pkg::SRC_EMPTY;
					end else begin
						head_d        = rrfo_pkg::ring_next(head_q);
						count_d       = count_q - ONE_CNT;
						s1_d.head_src = rrfo_pkg::SRC_RAM;
					end
				end
			end
			rrfo_pkg::OP_FLUSH: begin
				head_d        = '0;
				tail_d        = '0;
				count_d       = '0;
				s1_d.head_src = rrfo_pkg::SRC_EMPTY;
				s1_d.tail_src = rrfo_pkg::SRC_EMPTY;
			end
			rrfo_pkg::OP_NOP: begin
			end
		endcase
		s1_d.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (in_acc) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// byte store
	rrfo_ram #(
		.WIDTH (rrfo_pkg::BYTE_W),
		.DEPTH (rrfo_pkg::RING_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (in_acc && wr_en_c),
		.wr_addr (wr_addr_c),
		.wr_data (push_byte),
		.rd_en   (in_acc),
		.rd_addr (rd_addr_c),
		.rd_data (ram_rdata)
	);

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= in_acc || (s1_valid_s1 && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_s1 <= s1_d;
		end
	end

	// stage 1: resolve peeks and popped byte
	always_comb begin
		unique case (s1_s1.head_src)
			rrfo_pkg::SRC_KEEP:  head_new = head_peek_q;
			rrfo_pkg::SRC_DATA:  head_new = s1_s1.data;
			rrfo_pkg::SRC_RAM:   head_new = ram_rdata;
			rrfo_pkg::SRC_EMPTY: head_new = rrfo_pkg::EMPTY_BYTE;
		endcase
		unique case (s1_s1.tail_src)
			rrfo_pkg::SRC_KEEP,
			rrfo_pkg::SRC_RAM:   tail_new = tail_peek_q;
			rrfo_pkg::SRC_DATA:  tail_new = s1_s1.data;
			rrfo_pkg::SRC_EMPTY: tail_new = rrfo_pkg::EMPTY_BYTE;
		endcase
		rd_new = s1_s1.pop_hit ? head_peek_q : rrfo_pkg::EMPTY_BYTE;
	end

	// peek cache, FF while empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_peek_q <= rrfo_pkg::EMPTY_BYTE;
			tail_peek_q <= rrfo_pkg::EMPTY_BYTE;
		end else if (s1_adv) begin
			head_peek_q <= head_new;
			tail_peek_q <= tail_new;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_byte_q <= rd_new;
			was_empty_q <= s1_s1.was_empty;
			dropped_q   <= s1_s1.dropped;
			cnt_q       <= s1_s1.count;
			head_byte_q <= head_new;
			tail_byte_q <= tail_new;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_byte      = read_byte_q;
	assign read_was_empty = was_empty_q;
	assign dropped_oldest = dropped_q;
	assign fill_count     = rrfo_pkg::FILL_W'(cnt_q);
	assign head_byte      = head_byte_q;
	assign tail_byte      = tail_byte_q;

	// checks
	`RRFO_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= FULL_CNT,
		"ring count above depth")
	`RRFO_ASSERT_IMP(a_drop_full, clk, arst_n, out_valid_q && dropped_q,
		cnt_q == FULL_CNT, "drop reported while ring not full")
	`RRFO_ASSERT_IMP(a_empty_pop, clk, arst_n, out_valid_q && was_empty_q,
		(cnt_q == '0) && (read_byte_q == rrfo_pkg::EMPTY_BYTE)
		&& (head_byte_q == rrfo_pkg::EMPTY_BYTE), "empty pop result inconsistent")
	`RRFO_ASSERT_NXT(a_flush_clears, clk, arst_n,
		in_acc && (opcode == rrfo_pkg::OP_FLUSH), count_q == '0, "flush left bytes in ring")

endmodule

### hw/rtl/rrfo_ram.sv
// ----------------------------------------------------------------------------
// rrfo_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module rrfo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
